/* rtl/dec_pkg.sv */
// Shared types, constants and the day-of-year table for the expiry date classifier.
// No dependencies; every other rtl file imports this package.
package dec_pkg;

    // Pipeline depth: five work stages plus the output register
    localparam int NUM_STAGES = 6;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int NOW_W    = 64;
    localparam int WARN_W   = 16;
    localparam int STATUS_W = 2;

    // Internal widths: day numbers, second-domain thresholds and day-of-year bases
    localparam int DNUM_W   = 25;
    localparam int SEC_W    = 43;
    localparam int DOYB_W   = 9;

    // Era-based civil calendar constants
    localparam logic [10:0]              ERA_RECIP    = 11'd1311;   // ~2^15/25
    localparam logic signed [15:0]       YEARS_PER_ERA = 16'sd400;
    localparam logic signed [DNUM_W-1:0] DAYS_PER_ERA = 25'sd146097;
    localparam logic signed [DNUM_W-1:0] EPOCH_SHIFT  = 25'sd719468;
    localparam logic [17:0]              DAYS_PER_YEAR = 18'd365;
    localparam logic signed [SEC_W-1:0]  SEC_PER_DAY  = 43'sd86400;

    typedef logic [NUM_STAGES-1:0] t_stage_vec;

    typedef enum logic [STATUS_W-1:0] {
        VALIDITY_VALID   = 2'd0,
        VALIDITY_SOON    = 2'd1,
        VALIDITY_EXPIRED = 2'd2
    } t_validity;

    // Day-number bounds handed from the calendar stages to the compare stages
    typedef struct packed {
        logic signed [DNUM_W-1:0] exp_day;   // expiry day + 1
        logic signed [DNUM_W-1:0] soon_day;  // expiry day - window
    } t_day_bounds;

    // Days from March 1 to the first of shifted month mp: (153*mp + 2) / 5
    function automatic logic [DOYB_W-1:0] doy_base(input logic [MONTH_W-1:0] mp);
        logic [DOYB_W-1:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/date_expiry_classifier.sv */
// Top level of the expiry date classifier: ports, window register and the pipeline parts.
// Depends on dec_pkg, dec_pipe_ctrl, dec_civil_days and dec_expiry_cmp.
//
//   channel   handshake            payload
//   input     i_valid / o_ready    i_expiry_year, i_expiry_month, i_expiry_day, i_now_seconds
//   output    o_valid / i_ready    o_validity
//   config    i_cfg_we             i_cfg_wdata (warning window in days)
//
// Six register stages; with i_ready high, one item is taken every cycle. The calendar
// multiplies and the scaling to seconds set the stage split. Reset is synchronous, active
// low, clears the valid bits and the window register. A stall at the output holds each
// stage that is full; empty stages keep filling, so input is taken while a result waits.
module date_expiry_classifier import dec_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [WARN_W-1:0]       i_cfg_wdata,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [YEAR_W-1:0]       i_expiry_year,
    input  logic [MONTH_W-1:0]      i_expiry_month,
    input  logic [DAY_W-1:0]        i_expiry_day,
    input  logic signed [NOW_W-1:0] i_now_seconds,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [STATUS_W-1:0]     o_validity
);

    logic [WARN_W-1:0] r_warn_days;
    t_stage_vec        en;
    t_day_bounds       bounds;
    t_validity         validity;

    // Warning window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn_days <= '0;
        end else if (i_cfg_we) begin
            r_warn_days <= i_cfg_wdata;
        end
    end

    dec_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_en    (en)
    );

    dec_civil_days u_civil (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_year      (i_expiry_year),
        .i_month     (i_expiry_month),
        .i_day       (i_expiry_day),
        .i_warn_days (r_warn_days),
        .o_bounds    (bounds)
    );

    dec_expiry_cmp u_cmp (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_now      (i_now_seconds),
        .i_bounds   (bounds),
        .o_validity (validity)
    );

    assign o_validity = validity;

endmodule

/* rtl/dec_pipe_ctrl.sv */
// Valid bits and per-stage load enables for the classifier pipeline.
// Depends on dec_pkg. Bubbles are squeezed out: a stage loads when empty or moving on.
module dec_pipe_ctrl import dec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    output logic       o_valid,
    input  logic       i_ready,
    output t_stage_vec o_en
);

    t_stage_vec r_valid;
    t_stage_vec n_valid;
    t_stage_vec en;

    // Enable chain, from the output register back to the input
    always_comb begin
        en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        n_valid = r_valid;
        if (en[0]) begin
            n_valid[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_en    = en;
    assign o_ready = en[0];
    assign o_valid = r_valid[NUM_STAGES-1];

endmodule

/* rtl/dec_civil_days.sv */
// Calendar stages: expiry date to day number since 1970-01-01, then the two day bounds.
// Depends on dec_pkg. Uses load enables for stages 0 to 3.
module dec_civil_days import dec_pkg::*; (
    input  logic                 i_clk,
    input  t_stage_vec           i_en,
    input  logic [YEAR_W-1:0]    i_year,
    input  logic [MONTH_W-1:0]   i_month,
    input  logic [DAY_W-1:0]     i_day,
    input  logic [WARN_W-1:0]    i_warn_days,
    output t_day_bounds          o_bounds
);

    // Stage 0: shifted year, era, day of year
    logic                        early;
    logic signed [14:0]          y_s;
    logic [20:0]                 era_prod;
    logic signed [6:0]           era_0;
    logic [MONTH_W-1:0]          mp;
    logic signed [9:0]           doy_0;

    logic signed [14:0]          r_s0_y;
    logic signed [6:0]           r_s0_era;
    logic signed [9:0]           r_s0_doy;

    assign early    = (i_month <= 4'd2);
    assign y_s      = $signed({1'b0, i_year}) - (early ? 15'sd1 : 15'sd0);
    // floor(y/400) = floor((y>>4)/25), reciprocal multiply exact for y < 16384
    assign era_prod = 21'(y_s[13:4]) * 21'(ERA_RECIP);
    assign era_0    = y_s[14] ? -7'sd1 : $signed({1'b0, era_prod[20:15]});
    assign mp       = early ? (i_month + 4'd9) : (i_month - 4'd3);
    assign doy_0    = $signed({1'b0, doy_base(mp)}) + $signed({5'b0, i_day}) - 10'sd1;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_y   <= y_s;
            r_s0_era <= era_0;
            r_s0_doy <= doy_0;
        end
    end

    // Stage 1: year of era and day offset of the era
    logic signed [15:0]          yoe_w;
    logic [8:0]                  r_s1_yoe;
    logic signed [DNUM_W-1:0]    r_s1_era_days;
    logic signed [9:0]           r_s1_doy;

    assign yoe_w = 16'(r_s0_y) - 16'(r_s0_era) * YEARS_PER_ERA;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1_yoe      <= yoe_w[8:0];
            r_s1_era_days <= DNUM_W'(r_s0_era) * DAYS_PER_ERA;
            r_s1_doy      <= r_s0_doy;
        end
    end

    // Stage 2: day of era
    logic [1:0]                  cent;
    logic [17:0]                 doe_u;
    logic signed [18:0]          doe;
    logic signed [18:0]          r_s2_doe;
    logic signed [DNUM_W-1:0]    r_s2_era_days;

    always_comb begin
        if (r_s1_yoe >= 9'd300) begin
            cent = 2'd3;
        end else if (r_s1_yoe >= 9'd200) begin
            cent = 2'd2;
        end else if (r_s1_yoe >= 9'd100) begin
            cent = 2'd1;
        end else begin
            cent = 2'd0;
        end
    end

    assign doe_u = 18'(r_s1_yoe) * DAYS_PER_YEAR + 18'(r_s1_yoe[8:2]) - 18'(cent);
    assign doe   = $signed({1'b0, doe_u}) + 19'(r_s1_doy);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s2_doe      <= doe;
            r_s2_era_days <= r_s1_era_days;
        end
    end

    // Stage 3: day number, then the expired and expiring-soon bounds
    logic signed [DNUM_W-1:0]    days;
    t_day_bounds                 r_s3_bounds;

    assign days = r_s2_era_days + DNUM_W'(r_s2_doe) - EPOCH_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s3_bounds.exp_day  <= days + 25'sd1;
            r_s3_bounds.soon_day <= days - $signed({9'b0, i_warn_days});
        end
    end

    assign o_bounds = r_s3_bounds;

endmodule

/* rtl/dec_expiry_cmp.sv */
// Compare stages: day bounds scaled to seconds, then checked against the current time.
// Depends on dec_pkg. Holds the delay line for the time field and the output register.
module dec_expiry_cmp import dec_pkg::*; (
    input  logic                    i_clk,
    input  t_stage_vec              i_en,
    input  logic signed [NOW_W-1:0] i_now,
    input  t_day_bounds             i_bounds,
    output t_validity               o_validity
);

    // Time field travels alongside stages 0 to 4
    logic signed [NOW_W-1:0] r_now [NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_now[0] <= i_now;
        end
        for (int k = 1; k < NUM_STAGES - 1; k++) begin
            if (i_en[k]) begin
                r_now[k] <= r_now[k-1];
            end
        end
    end

    // Stage 4: floor(now/86400) >= d  <=>  now >= d*86400
    logic signed [SEC_W-1:0] r_s4_exp_sec;
    logic signed [SEC_W-1:0] r_s4_soon_sec;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s4_exp_sec  <= SEC_W'(i_bounds.exp_day) * SEC_PER_DAY;
            r_s4_soon_sec <= SEC_W'(i_bounds.soon_day) * SEC_PER_DAY;
        end
    end

    // Stage 5: classify into the output register
    logic      expired;
    logic      soon;
    t_validity n_validity;
    t_validity r_validity;

    assign expired = r_now[NUM_STAGES-2] >= NOW_W'(r_s4_exp_sec);
    assign soon    = r_now[NUM_STAGES-2] >= NOW_W'(r_s4_soon_sec);

    always_comb begin
        if (expired) begin
            n_validity = VALIDITY_EXPIRED;
        end else if (soon) begin
            n_validity = VALIDITY_SOON;
        end else begin
            n_validity = VALIDITY_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[NUM_STAGES-1]) begin
            r_validity <= n_validity;
        end
    end

    assign o_validity = r_validity;

endmodule
